[rtl/mfh_pkg.sv]
// Package for the mutex FIFO hand-off unit.
// Holds field widths, operation, status and lock-type codes, and the cell command types.
// No dependencies.
package mfh_pkg;

    localparam int unsigned DEF_MAX_WAITERS = 16;
    localparam int unsigned DEF_NEST_BITS   = 8;

    localparam int unsigned TID_W  = 8;
    localparam int unsigned OP_W   = 3;
    localparam int unsigned ST_W   = 3;
    localparam int unsigned TYPE_W = 2;

    typedef logic [TID_W-1:0] t_tid;

    localparam logic [OP_W-1:0] OP_LOCK     = 3'd0;
    localparam logic [OP_W-1:0] OP_TRYLOCK  = 3'd1;
    localparam logic [OP_W-1:0] OP_UNLOCK   = 3'd2;
    localparam logic [OP_W-1:0] OP_TIMED    = 3'd3;
    localparam logic [OP_W-1:0] OP_WITHDRAW = 3'd4;

    localparam logic [ST_W-1:0] ST_OK          = 3'd0;
    localparam logic [ST_W-1:0] ST_BUSY        = 3'd1;
    localparam logic [ST_W-1:0] ST_DEADLOCK    = 3'd2;
    localparam logic [ST_W-1:0] ST_NOT_OWNER   = 3'd3;
    localparam logic [ST_W-1:0] ST_TIMED_OUT   = 3'd4;
    localparam logic [ST_W-1:0] ST_UNSUPPORTED = 3'd5;
    localparam logic [ST_W-1:0] ST_QUEUED      = 3'd6;
    localparam logic [ST_W-1:0] ST_LIMIT       = 3'd7;

    localparam logic [TYPE_W-1:0] TYPE_NORMAL    = 2'd0;
    localparam logic [TYPE_W-1:0] TYPE_ERRCHK    = 2'd1;
    localparam logic [TYPE_W-1:0] TYPE_RECURSIVE = 2'd2;

    typedef enum logic [2:0] {
        CELL_IDLE,
        CELL_MATCH,
        CELL_PUSH,
        CELL_POP,
        CELL_REMOVE
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd cmd;
        t_tid      key;
    } t_cell_ctrl;

endpackage

[rtl/mfh_ifs.sv]
// Channel interfaces for the mutex FIFO hand-off unit: request, response and configuration.
// Depends on mfh_pkg.
interface mfh_req_if;
    import mfh_pkg::*;
    logic            valid;
    logic            ready;
    logic [OP_W-1:0] opcode;
    t_tid            thread_id;
    logic            deadline_passed;
    modport source (output valid, opcode, thread_id, deadline_passed, input ready);
    modport sink   (input valid, opcode, thread_id, deadline_passed, output ready);
endinterface

interface mfh_rsp_if;
    import mfh_pkg::*;
    logic            valid;
    logic            ready;
    logic [ST_W-1:0] status;
    t_tid            reply_thread;
    logic            grant_valid;
    t_tid            grant_thread;
    modport source (output valid, status, reply_thread, grant_valid, grant_thread, input ready);
    modport sink   (input valid, status, reply_thread, grant_valid, grant_thread, output ready);
endinterface

interface mfh_cfg_if;
    import mfh_pkg::*;
    logic              valid;
    logic              ready;
    logic [TYPE_W-1:0] lock_type;
    modport source (output valid, lock_type, input ready);
    modport sink   (input valid, lock_type, output ready);
endinterface

[rtl/mfh_cell.sv]
// One waiter slot of the queue chain: holds a thread number and its match flag.
// Depends on mfh_pkg.
module mfh_cell (
    input  logic               i_clk,
    input  mfh_pkg::t_cell_ctrl i_ctrl,
    input  logic               i_occupied,
    input  logic               i_at_tail,
    input  logic               i_hit_upto,
    input  mfh_pkg::t_tid      i_next_entry,
    output mfh_pkg::t_tid      o_entry,
    output logic               o_match
);
    import mfh_pkg::*;

    t_tid r_entry;
    t_tid n_entry;
    logic r_match;
    logic n_match;

    always_comb begin
        n_entry = r_entry;
        n_match = r_match;
        case (i_ctrl.cmd)
            CELL_MATCH: begin
                n_match = i_occupied && (r_entry == i_ctrl.key);
            end
            CELL_PUSH: begin
                if (i_at_tail) begin
                    n_entry = i_ctrl.key;
                end
            end
            CELL_POP: begin
                n_entry = i_next_entry;
            end
            CELL_REMOVE: begin
                // Every slot at or behind the withdrawn one takes its neighbor's entry.
                if (i_hit_upto) begin
                    n_entry = i_next_entry;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_match <= n_match;
    end

    assign o_entry = r_entry;
    assign o_match = r_match;

endmodule

[rtl/mutex_fifo_handoff_unit.sv]
// Top level of the mutex FIFO hand-off unit: control sequencer and the chain of waiter cells.
// Depends on mfh_pkg, the channel interfaces in mfh_ifs.sv and mfh_cell.
//
// The unit guards one lock on behalf of many threads. Each request transaction on i_req
// carries an opcode (lock, trylock, unlock, timed lock, timeout withdraw), the thread number
// and, for timed lock, a flag saying the deadline has already passed. Every request yields
// exactly one response transaction on o_rsp with a status, the thread it answers, and a grant
// flag plus thread when an unlock hands the lock to the oldest waiter.
// The lock type (normal, error-checking, recursive) is written through i_cfg, which is always
// ready; it should only be changed while no request is in flight.
// Timing: a request is taken in the idle state, the waiter cells compare against it in the
// next cycle, and the decision is then made and the response registered in S_EXEC. The
// response becomes valid at the same edge at which the unit goes back to idle and is ready
// again, so a new request is taken only after the previous one has been decided. The compare
// pass over the cell row runs in S_MATCH and the prefix search for a withdrawn waiter in S_EXEC.
// If the receiver stalls, a finished response stays in the output register; the next request
// may still be taken and run up to its decision, where it waits until the register frees up.
// Reset (synchronous, active low) frees the lock, empties the queue and selects normal type.
module mutex_fifo_handoff_unit #(
    parameter int unsigned MAX_WAITERS = mfh_pkg::DEF_MAX_WAITERS,
    parameter int unsigned NEST_BITS   = mfh_pkg::DEF_NEST_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mfh_req_if.sink       i_req,
    mfh_rsp_if.source     o_rsp,
    mfh_cfg_if.sink       i_cfg
);
    import mfh_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_WAITERS + 1);
    localparam int unsigned LVLS  = $clog2(MAX_WAITERS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_EXEC
    } t_state;

    t_state            r_state, n_state;
    logic [TYPE_W-1:0] r_lock_type;
    logic              r_owner_valid, n_owner_valid;
    t_tid              r_owner, n_owner;
    logic [NEST_BITS-1:0] r_nest, n_nest;
    logic [CNT_W-1:0]  r_count, n_count;

    // Latched request.
    logic [OP_W-1:0]   r_op, n_op;
    t_tid              r_tid, n_tid;
    logic              r_passed, n_passed;

    // Output register.
    logic              r_out_valid, n_out_valid;
    logic [ST_W-1:0]   r_status, n_status;
    t_tid              r_reply, n_reply;
    logic              r_gvalid, n_gvalid;
    t_tid              r_gthread, n_gthread;

    // Cell chain wiring.
    t_cell_cmd         w_cmd;
    t_cell_ctrl        w_ctrl;
    t_tid              w_entry [MAX_WAITERS];
    t_tid              w_next  [MAX_WAITERS];
    logic [MAX_WAITERS-1:0] w_match;
    logic [MAX_WAITERS-1:0] w_occupied;
    logic [MAX_WAITERS-1:0] w_at_tail;
    logic [MAX_WAITERS-1:0] w_hit;

    logic w_free;
    logic w_same;
    logic w_full;
    logic w_found;
    logic w_nest_max;

    assign w_ctrl = '{cmd: w_cmd, key: r_tid};

    for (genvar g = 0; g < MAX_WAITERS; g++) begin : g_cell
        assign w_occupied[g] = (CNT_W'(g) < r_count);
        assign w_at_tail[g]  = (CNT_W'(g) == r_count);
        if (g == MAX_WAITERS - 1) begin : g_last
            assign w_next[g] = w_entry[g];
        end else begin : g_mid
            assign w_next[g] = w_entry[g + 1];
        end
        mfh_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_occupied   (w_occupied[g]),
            .i_at_tail    (w_at_tail[g]),
            .i_hit_upto   (w_hit[g]),
            .i_next_entry (w_next[g]),
            .o_entry      (w_entry[g]),
            .o_match      (w_match[g])
        );
    end

    // Prefix OR of the registered match flags, in logarithmic levels: w_hit[i] is set when
    // the oldest matching waiter sits at slot i or before it.
    always_comb begin
        logic [MAX_WAITERS-1:0] acc;
        logic [MAX_WAITERS-1:0] prev;
        acc = w_match;
        for (int s = 0; s < LVLS; s++) begin
            prev = acc;
            for (int i = 0; i < MAX_WAITERS; i++) begin
                if (i >= (1 << s)) begin
                    acc[i] = prev[i] | prev[i - (1 << s)];
                end
            end
        end
        w_hit = acc;
    end

    assign w_free     = !r_owner_valid;
    assign w_same     = (r_owner == r_tid);
    assign w_full     = (r_count == CNT_W'(MAX_WAITERS));
    assign w_found    = w_hit[MAX_WAITERS-1];
    assign w_nest_max = (r_nest == {NEST_BITS{1'b1}});

    always_comb begin
        n_state       = r_state;
        n_owner_valid = r_owner_valid;
        n_owner       = r_owner;
        n_nest        = r_nest;
        n_count       = r_count;
        n_op          = r_op;
        n_tid         = r_tid;
        n_passed      = r_passed;
        n_out_valid   = r_out_valid && !o_rsp.ready;
        n_status      = r_status;
        n_reply       = r_reply;
        n_gvalid      = r_gvalid;
        n_gthread     = r_gthread;
        w_cmd         = CELL_IDLE;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op     = i_req.opcode;
                    n_tid    = i_req.thread_id;
                    n_passed = i_req.deadline_passed;
                    n_state  = S_MATCH;
                end
            end
            S_MATCH: begin
                w_cmd   = CELL_MATCH;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                // The decision commits only once the output register can take the response.
                if (!r_out_valid || o_rsp.ready) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_reply     = r_tid;
                    n_gvalid    = 1'b0;
                    n_gthread   = '0;
                    n_status    = ST_UNSUPPORTED;
                    case (r_op)
                        OP_LOCK, OP_TRYLOCK, OP_TIMED: begin
                            if (r_op == OP_TIMED &&
                                (r_lock_type == TYPE_ERRCHK || r_lock_type == TYPE_RECURSIVE)) begin
                                n_status = ST_UNSUPPORTED;
                            end else if (w_free) begin
                                // A free lock is taken at once, even by an expired timed lock.
                                n_owner_valid = 1'b1;
                                n_owner       = r_tid;
                                n_nest        = '0;
                                n_status      = ST_OK;
                            end else if (w_same && r_lock_type == TYPE_ERRCHK) begin
                                n_status = ST_DEADLOCK;
                            end else if (w_same && r_lock_type == TYPE_RECURSIVE) begin
                                if (w_nest_max) begin
                                    n_status = ST_LIMIT;
                                end else begin
                                    n_nest   = r_nest + 1'b1;
                                    n_status = ST_OK;
                                end
                            end else if (r_op == OP_TRYLOCK) begin
                                n_status = ST_BUSY;
                            end else if (r_op == OP_TIMED && r_passed) begin
                                n_status = ST_TIMED_OUT;
                            end else if (w_full) begin
                                n_status = ST_LIMIT;
                            end else begin
                                // Contended blocking request joins the tail of the queue.
                                w_cmd    = CELL_PUSH;
                                n_count  = r_count + 1'b1;
                                n_status = ST_QUEUED;
                            end
                        end
                        OP_UNLOCK: begin
                            if (w_free || !w_same) begin
                                n_status = ST_NOT_OWNER;
                            end else if (r_lock_type == TYPE_RECURSIVE && r_nest != '0) begin
                                n_nest   = r_nest - 1'b1;
                                n_status = ST_OK;
                            end else begin
                                n_nest   = '0;
                                n_status = ST_OK;
                                if (r_count != '0) begin
                                    // Hand the lock to the oldest waiter and advance the chain.
                                    w_cmd     = CELL_POP;
                                    n_owner   = w_entry[0];
                                    n_count   = r_count - 1'b1;
                                    n_gvalid  = 1'b1;
                                    n_gthread = w_entry[0];
                                end else begin
                                    n_owner_valid = 1'b0;
                                    n_owner       = '0;
                                end
                            end
                        end
                        OP_WITHDRAW: begin
                            if (w_found) begin
                                w_cmd    = CELL_REMOVE;
                                n_count  = r_count - 1'b1;
                                n_status = ST_TIMED_OUT;
                            end else if (r_owner_valid && w_same) begin
                                // Its grant arrived before the withdrawal.
                                n_status = ST_OK;
                            end else begin
                                n_status = ST_TIMED_OUT;
                            end
                        end
                        default: begin
                            n_status = ST_UNSUPPORTED;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_lock_type   <= TYPE_NORMAL;
            r_owner_valid <= 1'b0;
            r_owner       <= '0;
            r_nest        <= '0;
            r_count       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_owner_valid <= n_owner_valid;
            r_owner       <= n_owner;
            r_nest        <= n_nest;
            r_count       <= n_count;
            r_out_valid   <= n_out_valid;
            r_op          <= n_op;
            r_tid         <= n_tid;
            r_passed      <= n_passed;
            r_status      <= n_status;
            r_reply       <= n_reply;
            r_gvalid      <= n_gvalid;
            r_gthread     <= n_gthread;
            if (i_cfg.valid) begin
                r_lock_type <= i_cfg.lock_type;
            end
        end
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign i_cfg.ready        = 1'b1;
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_status;
    assign o_rsp.reply_thread = r_reply;
    assign o_rsp.grant_valid  = r_gvalid;
    assign o_rsp.grant_thread = r_gthread;

endmodule
